// ----- hw/rtl/gspt_pkg.sv -----
// ----------------------------------------------------------------------------
// gspt_pkg: shared definitions for the gyro swing peak trigger
// Default window length, register map, item kinds and status codes.
// ----------------------------------------------------------------------------
package gspt_pkg;

    localparam int WINDOW_LEN_DEF = 52;

    // register map, word index (byte address / 4)
    localparam logic [1:0] REG_SWING_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_PEAK_POSITION      = 2'd1;
    localparam logic [1:0] REG_REFRACTORY_SAMPLES = 2'd2;

    localparam logic [15:0] SWING_THRESHOLD_RST    = 16'd2000;
    localparam logic [5:0]  PEAK_POSITION_RST      = 6'd26;
    localparam logic [15:0] REFRACTORY_SAMPLES_RST = 16'd52;

    // item kinds
    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_PUBLISH = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // status codes
    localparam logic [1:0] ST_COLLECTING = 2'd0;
    localparam logic [1:0] ST_ACTIVE     = 2'd1;
    localparam logic [1:0] ST_LOCKED     = 2'd2;
    localparam logic [1:0] ST_WAITING    = 2'd3;

endpackage

// ----- hw/rtl/gyro_swing_peak_trigger.sv -----
// ----------------------------------------------------------------------------
// gyro_swing_peak_trigger
// Swing peak detector with refractory period on a three-axis gyro stream.
// ----------------------------------------------------------------------------
// One item in, one result item out. A sample item's result is offered after
// four passes through one shared 16x16 multiplier (x, y and z squared, then
// the threshold squared), an update state and an 18-step bit-serial square
// root of the peak's sum of squares. Publish and restart items skip the
// multiplier and go straight to the update state and the square root. The
// input side is not ready from acceptance until the result item has been
// taken and is ready again the cycle after. Registers (APB, byte addresses):
// 0x0 swing_threshold, 0x4 peak_position, 0x8 refractory_samples; write them
// only while idle.
// ----------------------------------------------------------------------------
module gyro_swing_peak_trigger
    import gspt_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // gyro_x[15:0], gyro_y[31:16], gyro_z[47:32]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // trigger[0], window_ready[1], status[3:2],
                                   // peak_index[35:4], peak_magnitude[51:36],
                                   // newest_index[83:52], zero[87:84]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [31:0] WIN = 32'(WINDOW_LEN);
    localparam int SQRT_STEPS = 18;   // bit runs 2^34 down to 2^0, a factor of four per step

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPDATE,
        S_SQRT,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [15:0] swing_threshold_reg;
    logic [5:0]  peak_position_reg;
    logic [15:0] refractory_samples_reg;

    // captured item
    logic [1:0]  action_reg;
    logic [15:0] gyro_x_reg, gyro_y_reg, gyro_z_reg;

    // detector state
    logic [31:0] sample_count_reg;
    logic        below_seen_reg;
    logic        swing_active_reg;
    logic [31:0] peak_at_reg;
    logic [33:0] peak_square_reg;
    logic [31:0] rearm_index_reg;

    // datapath
    logic [1:0]  mul_cnt_reg;
    logic [33:0] sum_reg;
    logic [31:0] thr2_reg;
    logic [35:0] rem_reg;
    logic [35:0] root_reg;
    logic [35:0] bit_reg;
    logic [4:0]  sqrt_cnt_reg;

    // registered result fields
    logic        trigger_reg;
    logic        window_ready_reg;
    logic [1:0]  status_reg;
    logic [31:0] newest_index_reg;

    // ------------------------------------------------------------------
    // Configuration port: write on the access phase, read back at once
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SWING_THRESHOLD:    prdata = {16'd0, swing_threshold_reg};
            REG_PEAK_POSITION:      prdata = {26'd0, peak_position_reg};
            REG_REFRACTORY_SAMPLES: prdata = {16'd0, refractory_samples_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swing_threshold_reg    <= SWING_THRESHOLD_RST;
            peak_position_reg      <= PEAK_POSITION_RST;
            refractory_samples_reg <= REFRACTORY_SAMPLES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SWING_THRESHOLD:    swing_threshold_reg    <= pwdata[15:0];
                REG_PEAK_POSITION:      peak_position_reg      <= pwdata[5:0];
                REG_REFRACTORY_SAMPLES: refractory_samples_reg <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: magnitude of one operand, squared
    // ------------------------------------------------------------------
    logic [15:0] mul_raw;
    logic [15:0] mul_mag;
    logic [31:0] mul_prod;

    always_comb
    begin
        unique case (mul_cnt_reg)
            2'd0:    mul_raw = gyro_x_reg;
            2'd1:    mul_raw = gyro_y_reg;
            2'd2:    mul_raw = gyro_z_reg;
            default: mul_raw = swing_threshold_reg;
        endcase
        // threshold is unsigned; axes are two's complement (-32768 gives 0x8000)
        if (mul_cnt_reg != 2'd3 && mul_raw[15])
            mul_mag = 16'(~mul_raw + 16'd1);
        else
            mul_mag = mul_raw;
    end

    assign mul_prod = 32'(mul_mag) * 32'(mul_mag);

    // ------------------------------------------------------------------
    // Detector update: next state and result fields for this item
    // ------------------------------------------------------------------
    logic [31:0] after_peak;
    logic [31:0] idx;
    logic [31:0] sample_count_next;
    logic        below_seen_next;
    logic        swing_active_next;
    logic [31:0] peak_at_next;
    logic [33:0] peak_square_next;
    logic [31:0] rearm_index_next;
    logic        trigger_next;
    logic [1:0]  status_next;
    logic [31:0] since_peak;
    logic [31:0] since_rearm;
    logic [31:0] status_diff;

    // samples needed after the peak, saturating at zero
    always_comb
    begin
        if (32'(peak_position_reg) + 32'd1 >= WIN)
            after_peak = 32'd0;
        else
            after_peak = WIN - 32'(peak_position_reg) - 32'd1;
    end

    always_comb
    begin
        idx               = sample_count_reg;
        sample_count_next = sample_count_reg;
        below_seen_next   = below_seen_reg;
        swing_active_next = swing_active_reg;
        peak_at_next      = peak_at_reg;
        peak_square_next  = peak_square_reg;
        rearm_index_next  = rearm_index_reg;
        trigger_next      = 1'b0;
        since_peak        = sample_count_reg - peak_at_reg;
        since_rearm       = sample_count_reg - rearm_index_reg;

        unique case (action_reg)
            ACT_SAMPLE:
            begin
                sample_count_next = sample_count_reg + 32'd1;
                if (swing_active_reg)
                begin
                    if (sum_reg > peak_square_reg)
                    begin
                        peak_at_next     = idx;
                        peak_square_next = sum_reg;
                    end
                    else if (since_peak >= after_peak)
                    begin
                        swing_active_next = 1'b0;
                        below_seen_next   = 1'b0;
                        trigger_next      = 1'b1;
                    end
                end
                else if (sum_reg < 34'(thr2_reg))
                begin
                    below_seen_next = 1'b1;
                end
                else if (below_seen_reg && !since_rearm[31])
                begin
                    swing_active_next = 1'b1;
                    peak_at_next      = idx;
                    peak_square_next  = sum_reg;
                end
            end
            ACT_RESTART:
            begin
                idx               = 32'd0;
                sample_count_next = 32'd0;
                below_seen_next   = 1'b0;
                swing_active_next = 1'b0;
                peak_at_next      = 32'd0;
                peak_square_next  = 34'd0;
                rearm_index_next  = 32'd0;
            end
            default:
            begin
                // publish moves the rearm point; the unused code changes nothing
                if (action_reg == ACT_PUBLISH)
                    rearm_index_next = peak_at_reg + 32'(refractory_samples_reg);
                idx = sample_count_reg - 32'd1;
            end
        endcase

        status_diff = idx - rearm_index_next;
        if (sample_count_next < WIN)
            status_next = ST_COLLECTING;
        else if (swing_active_next)
            status_next = ST_ACTIVE;
        else if (status_diff[31])
            status_next = ST_LOCKED;
        else
            status_next = ST_WAITING;
    end

    // ------------------------------------------------------------------
    // Square root step: one result bit per cycle
    // ------------------------------------------------------------------
    logic [35:0] trial;
    assign trial = root_reg + bit_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            action_reg       <= ACT_SAMPLE;
            gyro_x_reg       <= 16'd0;
            gyro_y_reg       <= 16'd0;
            gyro_z_reg       <= 16'd0;
            sample_count_reg <= 32'd0;
            below_seen_reg   <= 1'b0;
            swing_active_reg <= 1'b0;
            peak_at_reg      <= 32'd0;
            peak_square_reg  <= 34'd0;
            rearm_index_reg  <= 32'd0;
            mul_cnt_reg      <= 2'd0;
            sum_reg          <= 34'd0;
            thr2_reg         <= 32'd0;
            rem_reg          <= 36'd0;
            root_reg         <= 36'd0;
            bit_reg          <= 36'd0;
            sqrt_cnt_reg     <= 5'd0;
            trigger_reg      <= 1'b0;
            window_ready_reg <= 1'b0;
            status_reg       <= ST_COLLECTING;
            newest_index_reg <= 32'd0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        action_reg  <= s_tuser;
                        gyro_x_reg  <= s_tdata[15:0];
                        gyro_y_reg  <= s_tdata[31:16];
                        gyro_z_reg  <= s_tdata[47:32];
                        mul_cnt_reg <= 2'd0;
                        sum_reg     <= 34'd0;
                        // only samples need the squares
                        state_reg   <= (s_tuser == ACT_SAMPLE) ? S_MUL : S_UPDATE;
                    end
                end
                S_MUL:
                begin
                    if (mul_cnt_reg == 2'd3)
                    begin
                        thr2_reg  <= mul_prod;
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        sum_reg <= sum_reg + 34'(mul_prod);
                    end
                    mul_cnt_reg <= mul_cnt_reg + 2'd1;
                end
                S_UPDATE:
                begin
                    sample_count_reg <= sample_count_next;
                    below_seen_reg   <= below_seen_next;
                    swing_active_reg <= swing_active_next;
                    peak_at_reg      <= peak_at_next;
                    peak_square_reg  <= peak_square_next;
                    rearm_index_reg  <= rearm_index_next;
                    trigger_reg      <= trigger_next;
                    window_ready_reg <= (sample_count_next >= WIN);
                    status_reg       <= status_next;
                    newest_index_reg <= idx;
                    // load the root of the peak's sum of squares
                    rem_reg          <= 36'(peak_square_next);
                    root_reg         <= 36'd0;
                    bit_reg          <= 36'd1 << 34;
                    sqrt_cnt_reg     <= 5'd0;
                    state_reg        <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg      <= bit_reg >> 2;
                    sqrt_cnt_reg <= sqrt_cnt_reg + 5'd1;
                    if (sqrt_cnt_reg == 5'(SQRT_STEPS - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold the result until taken
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and result packing
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);

    assign m_tdata = {
        4'd0,
        newest_index_reg,
        root_reg[15:0],
        peak_at_reg,
        status_reg,
        window_ready_reg,
        trigger_reg
    };

endmodule
